>>> rtl/cst_pkg.sv
// Shared types, constants and helpers for the counting semaphore table.
// Used by cst_alu and counting_semaphore_table_core; no dependencies.
package cst_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int COUNT_BITS = 16;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TOTAL_W    = $clog2(SLOT_COUNT + 1);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam longint CNT_MAX = (longint'(1) << (COUNT_BITS - 1)) - 1;
    localparam longint CNT_MIN = -CNT_MAX - 1;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_P      = 2'd1,
        MODE_V      = 2'd2,
        MODE_FREE   = 2'd3
    } mode_t;

    typedef logic signed [COUNT_BITS-1:0] count_t;
    typedef logic [SLOT_IDX_W-1:0]        slot_idx_t;

    typedef struct packed {
        count_t count;
        logic   must_block;
        logic   wake_one;
    } alu_res_t;

    typedef struct packed {
        logic signed [15:0] count_after;
        logic               wake_one;
        logic               must_block;
        logic [4:0]         granted_slot;
        logic               status;
    } result_t;

    function automatic count_t clamp_init(input logic signed [15:0] v);
        longint w;
        w = longint'(v);
        if (w > CNT_MAX) begin
            return count_t'(CNT_MAX);
        end
        if (w < CNT_MIN) begin
            return count_t'(CNT_MIN);
        end
        return count_t'(w);
    endfunction

endpackage

>>> rtl/cst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/cst_alu.sv
// Saturating step unit for semaphore counts: decrement for P, increment for V,
// with the block and wake flags. Depends on cst_pkg.
module cst_alu (
    input  cst_pkg::count_t   count_in,
    input  logic              dec,
    output cst_pkg::alu_res_t res
);

    cst_pkg::count_t nxt;

    always_comb begin
        if (dec) begin
            nxt = (count_in == cst_pkg::count_t'(cst_pkg::CNT_MIN)) ?
                  count_in : count_in - cst_pkg::count_t'(1);
        end else begin
            nxt = (count_in == cst_pkg::count_t'(cst_pkg::CNT_MAX)) ?
                  count_in : count_in + cst_pkg::count_t'(1);
        end
        res.count      = nxt;
        res.must_block = dec & nxt[cst_pkg::COUNT_BITS-1];
        res.wake_one   = ~dec & (nxt[cst_pkg::COUNT_BITS-1] | (nxt == '0));
    end

endmodule

>>> rtl/counting_semaphore_table_core.sv
// Counting semaphore table: top level with sequencer, slot marks and count RAM.
// Depends on cst_pkg, cst_ram and cst_alu.
//
// One request beat on s_ gives exactly one result beat on m_.
// Request: mode (create, P, V, free), slot_number, initial_count.
// Result: status, granted_slot, must_block, wake_one, count_after.
// Create scans the slot marks one slot per cycle from slot 0 for the lowest
// free slot; a full table fails at once. P and V read the count RAM
// (registered read), step it through the saturating unit and write it back.
// Free and any failing request go straight to the result state. One request
// is in flight at a time; s_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next request is taken while
// a result waits; a request that finishes while m_tready is low holds until
// the output register drains.
// Synchronous reset clears all slot marks and the allocation total at once;
// the count RAM needs no clearing since a count is read only after a create.
module counting_semaphore_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[1:0], slot_number[6:2], initial_count[22:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[0], granted_slot[5:1], must_block[6],
                                   // wake_one[7], count_after[23:8]
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_CALC  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [cst_pkg::SLOT_COUNT-1:0]  in_use_reg, in_use_next;
    logic [cst_pkg::TOTAL_W-1:0]     total_reg, total_next;
    cst_pkg::slot_idx_t              idx_reg, idx_next;
    cst_pkg::slot_idx_t              slot_idx_reg, slot_idx_next;
    cst_pkg::mode_t                  mode_reg, mode_next;
    logic signed [15:0]              init_reg, init_next;
    cst_pkg::result_t                res_reg, res_next;
    cst_pkg::result_t                out_reg, out_next;
    logic                            m_valid_reg, m_valid_next;

    cst_pkg::mode_t                  in_mode;
    logic [4:0]                      in_slot;
    logic signed [15:0]              in_init;
    cst_pkg::slot_idx_t              in_idx;
    logic                            in_slot_ok;
    cst_pkg::count_t                 init_clamped;

    logic                            ram_we;
    cst_pkg::slot_idx_t              ram_waddr;
    cst_pkg::count_t                 ram_wdata;
    logic                            ram_re;
    cst_pkg::count_t                 ram_rdata;
    cst_pkg::alu_res_t               alu_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    assign in_mode    = cst_pkg::mode_t'(s_tdata[1:0]);
    assign in_slot    = s_tdata[6:2];
    assign in_init    = s_tdata[22:7];
    assign in_idx     = cst_pkg::slot_idx_t'(in_slot);
    assign in_slot_ok = (32'(in_slot) < cst_pkg::SLOT_COUNT) && in_use_reg[in_idx];

    assign init_clamped = cst_pkg::clamp_init(init_reg);

    cst_ram #(
        .WIDTH (cst_pkg::COUNT_BITS),
        .DEPTH (cst_pkg::SLOT_COUNT)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_idx_reg),
        .rdata (ram_rdata)
    );

    cst_alu u_alu (
        .count_in (ram_rdata),
        .dec      (mode_reg == cst_pkg::MODE_P),
        .res      (alu_res)
    );

    always_comb begin
        state_next    = state_reg;
        in_use_next   = in_use_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        slot_idx_next = slot_idx_reg;
        mode_next     = mode_reg;
        init_next     = init_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = init_clamped;
        ram_re        = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next     = in_mode;
                    slot_idx_next = in_idx;
                    init_next     = in_init;
                    res_next      = '0;
                    res_next.status = 1'b1;
                    state_next    = ST_DONE;
                    if (in_mode == cst_pkg::MODE_CREATE) begin
                        if (total_reg != cst_pkg::TOTAL_W'(cst_pkg::SLOT_COUNT)) begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end else if (in_slot_ok) begin
                        if (in_mode == cst_pkg::MODE_FREE) begin
                            in_use_next[in_idx] = 1'b0;
                            total_next          = total_reg - cst_pkg::TOTAL_W'(1);
                            res_next.status     = 1'b0;
                        end else begin
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (!in_use_reg[idx_reg]) begin
                    in_use_next[idx_reg]  = 1'b1;
                    total_next            = total_reg + cst_pkg::TOTAL_W'(1);
                    ram_we                = 1'b1;
                    res_next              = '0;
                    res_next.granted_slot = 5'(idx_reg);
                    res_next.count_after  = 16'(init_clamped);
                    state_next            = ST_DONE;
                end else begin
                    idx_next = idx_reg + cst_pkg::slot_idx_t'(1);
                end
            end
            ST_FETCH: begin
                ram_re     = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                ram_we              = 1'b1;
                ram_waddr           = slot_idx_reg;
                ram_wdata           = alu_res.count;
                res_next            = '0;
                res_next.must_block = alu_res.must_block;
                res_next.wake_one   = alu_res.wake_one;
                res_next.count_after = 16'(alu_res.count);
                state_next          = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        slot_idx_reg <= slot_idx_next;
        mode_reg     <= mode_next;
        init_reg     <= init_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    a_total_matches_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(total_reg) == $countones(in_use_reg))
        else $error("allocation total differs from slot marks");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_scan_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (32'(total_reg) < cst_pkg::SLOT_COUNT))
        else $error("create scan running on a full table");

    a_calc_allocated: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> in_use_reg[slot_idx_reg])
        else $error("count step on an unallocated slot");

endmodule
